>>> rtl/core/assert_macros.svh
// Assertion macros used by the command ring tracker back end.
// No dependencies; files that assert include this header by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define CRT_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the following cycle.
`define CRT_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/crt_pkg.sv
// Package for the command ring tracker: ring geometry, codes and the
// item and result structures shared by the front, back and top level.
package crt_pkg;

    localparam int RING_BYTES  = 65536;
    localparam int MAX_BATCH   = 4;
    localparam int ENTRY_BYTES = 32;
    localparam int RING_W      = $clog2(RING_BYTES);
    localparam int ROW_W       = RING_W - $clog2(ENTRY_BYTES);
    localparam int RING_ROWS   = RING_BYTES / ENTRY_BYTES;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        OP_BEGIN    = 2'd0,
        OP_COMMAND  = 2'd1,
        OP_POLL     = 2'd2,
        OP_DEADLINE = 2'd3
    } crt_op_t;

    typedef enum logic [2:0] {
        K_BEGIN,
        K_BAD_COUNT,
        K_COMMAND,
        K_POLL,
        K_DEADLINE
    } crt_kind_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_REJECT  = 2'd1,
        ST_FAULT   = 2'd2,
        ST_PENDING = 2'd3
    } crt_status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_APPLY,
        S_FINAL
    } crt_state_t;

    typedef struct packed {
        crt_kind_t          kind;
        logic [RING_W-1:0]  rd_low;
        logic               rd_bad;
        logic [2:0]         count;
        logic [63:0]        word3;
        logic [63:0]        word2;
        logic [63:0]        word1;
        logic [63:0]        word0;
        logic [63:0]        ticket;
    } crt_item_t;

    typedef struct packed {
        crt_status_t  status;
        logic [63:0]  ticket_out;
        logic [15:0]  write_offset;
        logic         doorbell;
        logic         engine_disable;
        logic         fault_alert;
    } crt_result_t;

endpackage

>>> rtl/core/its_command_ring_tracker_unit.sv
// Top level of the command ring tracker: joins the classifying front end
// and the executing back end. Uses crt_pkg, crt_front and crt_back.
//
// Input beats are pushed with push while full is low. Each beat is one
// of begin batch, command entry, poll completion or deadline expired.
// Every input beat gives exactly one result beat, in order. A result is
// shown while empty is low and is taken with pop.
// The front end queues up to two classified beats. The back end runs
// them one at a time: a command entry, deadline, rejected begin or a
// beat that meets a fault or fails its progress check finishes in the
// check state; a begin or poll that passes the check goes on to the
// apply state for the counter update and the final state for the room or
// ticket compare. When pop stays low the finished result holds its
// register, the back end waits before starting the next beat, and full
// rises once the queue holds two beats.
// Reset clears the counters, the fault flag, the open batch, the queues
// and the notify register; the ring memory is not cleared. The notify
// register is written with cfg_write and cfg_wdata; the user must do so
// only while the block is idle, which the block itself does not enforce.
module its_command_ring_tracker_unit
    import crt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic        cfg_wdata,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  opcode,
    input  logic [31:0] read_pointer,
    input  logic [2:0]  batch_count,
    input  logic [63:0] command_word0,
    input  logic [63:0] command_word1,
    input  logic [63:0] command_word2,
    input  logic [63:0] command_word3,
    input  logic [63:0] ticket,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  status,
    output logic [63:0] ticket_out,
    output logic [15:0] write_offset,
    output logic        doorbell,
    output logic        engine_disable,
    output logic        fault_alert
);

    logic         head_valid;
    logic         head_pop;
    crt_item_t    head_item;
    crt_result_t  result;

    crt_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .opcode        (opcode),
        .read_pointer  (read_pointer),
        .batch_count   (batch_count),
        .command_word0 (command_word0),
        .command_word1 (command_word1),
        .command_word2 (command_word2),
        .command_word3 (command_word3),
        .ticket        (ticket),
        .head_valid    (head_valid),
        .head_pop      (head_pop),
        .head_item     (head_item)
    );

    crt_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_wdata  (cfg_wdata),
        .head_valid (head_valid),
        .head_pop   (head_pop),
        .head_item  (head_item),
        .empty      (empty),
        .pop        (pop),
        .result     (result)
    );

    assign status         = result.status;
    assign ticket_out     = result.ticket_out;
    assign write_offset   = result.write_offset;
    assign doorbell       = result.doorbell;
    assign engine_disable = result.engine_disable;
    assign fault_alert    = result.fault_alert;

endmodule

>>> rtl/core/crt_front.sv
// Front end of the command ring tracker: accepts input beats, classifies
// them and holds them in a short queue for the back end. Uses crt_pkg.
module crt_front
    import crt_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  opcode,
    input  logic [31:0] read_pointer,
    input  logic [2:0]  batch_count,
    input  logic [63:0] command_word0,
    input  logic [63:0] command_word1,
    input  logic [63:0] command_word2,
    input  logic [63:0] command_word3,
    input  logic [63:0] ticket,
    output logic        head_valid,
    input  logic        head_pop,
    output crt_item_t   head_item
);

    crt_item_t           q_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg;
    logic [QCNT_W-1:0]   count_next;
    logic                do_push;
    logic                do_pop;
    crt_item_t           item;

    always_comb
    begin
        item.rd_low = read_pointer[RING_W-1:0];
        // Offsets must be entry aligned and lie inside the ring.
        item.rd_bad = (|read_pointer[31:RING_W]) || (|read_pointer[4:0]);
        item.count  = batch_count;
        item.word0  = command_word0;
        item.word1  = command_word1;
        item.word2  = command_word2;
        item.word3  = command_word3;
        item.ticket = ticket;
        case (crt_op_t'(opcode))
            OP_BEGIN:
            begin
                if (batch_count == 3'd0 || batch_count > 3'(MAX_BATCH))
                    item.kind = K_BAD_COUNT;
                else
                    item.kind = K_BEGIN;
            end
            OP_COMMAND: item.kind = K_COMMAND;
            OP_POLL:    item.kind = K_POLL;
            default:    item.kind = K_DEADLINE;
        endcase
    end

    assign full       = (count_reg == QCNT_W'(QDEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = q_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = head_pop && head_valid;

    // The queue depth is a power of two, so the pointers wrap naturally.
    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + QCNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            q_reg[wr_ptr_reg] <= item;
    end

endmodule

>>> rtl/core/crt_back.sv
// Back end of the command ring tracker: a sequencer that carries out one
// queued item at a time, owns the ring counters, the ring memory and the
// result register. Uses crt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module crt_back
    import crt_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_write,
    input  logic         cfg_wdata,
    input  logic         head_valid,
    output logic         head_pop,
    input  crt_item_t    head_item,
    output logic         empty,
    input  logic         pop,
    output crt_result_t  result
);

    crt_state_t          state_reg;
    crt_state_t          state_next;
    crt_item_t           cur_reg;
    logic [63:0]         produced_reg;
    logic [63:0]         produced_next;
    logic [63:0]         consumed_reg;
    logic [63:0]         consumed_next;
    logic [RING_W-1:0]   outstanding_reg;
    logic [RING_W-1:0]   outstanding_next;
    logic [RING_W-1:0]   delta_reg;
    logic [RING_W-1:0]   delta;
    logic                fault_reg;
    logic                fault_next;
    logic [2:0]          remaining_reg;
    logic [2:0]          remaining_next;
    logic                notify_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    crt_result_t         out_reg;
    crt_result_t         res;
    logic                result_we;
    logic                new_fault;
    logic                pop_ok;
    logic                prog_bad;
    logic [7:0]          bytes;
    logic [RING_W:0]     room_sum;
    logic                room_bad;
    logic [64:0]         ovf_sum;
    logic [63:0]         prod_inc;
    logic [63:0]         prod_masked;
    logic                ring_we;
    logic [255:0]        ring_mem [RING_ROWS];

    assign pop_ok   = pop && out_valid_reg;
    assign head_pop = (state_reg == S_IDLE) && head_valid && (!out_valid_reg || pop_ok);
    assign empty    = !out_valid_reg;
    assign result   = out_reg;

    assign delta       = cur_reg.rd_low - consumed_reg[RING_W-1:0];
    assign prog_bad    = cur_reg.rd_bad || (delta > outstanding_reg);
    assign bytes       = {cur_reg.count, 5'b0};
    assign room_sum    = {1'b0, outstanding_reg} + (RING_W+1)'(bytes);
    assign room_bad    = (room_sum >= (RING_W+1)'(RING_BYTES));
    assign ovf_sum     = {1'b0, produced_reg} + 65'(bytes);
    assign prod_inc    = produced_reg + 64'(ENTRY_BYTES);
    assign prod_masked = prod_inc & 64'(RING_BYTES - 1);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (head_pop)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = S_IDLE;
                if (cur_reg.kind == K_BEGIN && remaining_reg == 3'd0 && !fault_reg
                    && !prog_bad)
                    state_next = S_APPLY;
                else if (cur_reg.kind == K_POLL && !fault_reg && !prog_bad)
                    state_next = S_APPLY;
            end
            S_APPLY: state_next = S_FINAL;
            S_FINAL: state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        res              = '0;
        result_we        = 1'b0;
        new_fault        = 1'b0;
        ring_we          = 1'b0;
        produced_next    = produced_reg;
        consumed_next    = consumed_reg;
        outstanding_next = outstanding_reg;
        fault_next       = fault_reg;
        remaining_next   = remaining_reg;
        case (state_reg)
            S_CHECK:
            begin
                case (cur_reg.kind)
                    K_BAD_COUNT:
                    begin
                        res.status = ST_REJECT;
                        result_we  = 1'b1;
                    end
                    K_BEGIN, K_POLL:
                    begin
                        if (cur_reg.kind == K_BEGIN && remaining_reg != 3'd0)
                        begin
                            res.status = ST_REJECT;
                            result_we  = 1'b1;
                        end
                        else if (fault_reg)
                        begin
                            res.status = ST_FAULT;
                            result_we  = 1'b1;
                        end
                        else if (prog_bad)
                        begin
                            fault_next     = 1'b1;
                            new_fault      = 1'b1;
                            remaining_next = 3'd0;
                            res.status     = ST_FAULT;
                            result_we      = 1'b1;
                        end
                    end
                    K_COMMAND:
                    begin
                        result_we = 1'b1;
                        if (remaining_reg == 3'd0)
                        begin
                            res.status = fault_reg ? ST_FAULT : ST_REJECT;
                        end
                        else
                        begin
                            ring_we          = 1'b1;
                            produced_next    = prod_inc;
                            outstanding_next = outstanding_reg + RING_W'(ENTRY_BYTES);
                            remaining_next   = remaining_reg - 3'd1;
                            res.status       = ST_OK;
                            if (remaining_reg == 3'd1)
                            begin
                                res.ticket_out   = prod_inc;
                                res.write_offset = prod_masked[15:0];
                                res.doorbell     = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        // Deadline expiry: faults, first time only pulses the outputs.
                        new_fault      = !fault_reg;
                        fault_next     = 1'b1;
                        remaining_next = 3'd0;
                        res.status     = ST_FAULT;
                        result_we      = 1'b1;
                    end
                endcase
            end
            S_APPLY:
            begin
                consumed_next    = consumed_reg + 64'(delta_reg);
                outstanding_next = outstanding_reg - delta_reg;
            end
            S_FINAL:
            begin
                result_we = 1'b1;
                if (cur_reg.kind == K_POLL)
                begin
                    res.status = (consumed_reg >= cur_reg.ticket) ? ST_OK : ST_PENDING;
                end
                else if (room_bad || ovf_sum[64])
                begin
                    res.status = ST_REJECT;
                end
                else
                begin
                    res.status     = ST_OK;
                    remaining_next = cur_reg.count;
                end
            end
            default:
            begin
                res = '0;
            end
        endcase
        res.engine_disable = new_fault;
        res.fault_alert    = new_fault && notify_reg;
    end

    assign out_valid_next = (out_valid_reg && !pop_ok) || result_we;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            produced_reg    <= '0;
            consumed_reg    <= '0;
            outstanding_reg <= '0;
            fault_reg       <= 1'b0;
            remaining_reg   <= 3'd0;
            notify_reg      <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            produced_reg    <= produced_next;
            consumed_reg    <= consumed_next;
            outstanding_reg <= outstanding_next;
            fault_reg       <= fault_next;
            remaining_reg   <= remaining_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_write)
                notify_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (head_pop)
            cur_reg <= head_item;
        if (state_reg == S_CHECK)
            delta_reg <= delta;
        if (result_we)
            out_reg <= res;
    end

    // Each entry occupies one row; word0 sits in the low bits.
    always_ff @(posedge clk)
    begin
        if (ring_we)
            ring_mem[produced_reg[RING_W-1:5]] <= {cur_reg.word3, cur_reg.word2,
                                                    cur_reg.word1, cur_reg.word0};
    end

    `CRT_ASSERT_IMPL(a_open_batch_unfaulted, clk, rst_n, remaining_reg != 3'd0,
        !fault_reg, "open batch while faulted")
    `CRT_ASSERT_IMPL(a_result_slot_free, clk, rst_n, result_we,
        !out_valid_reg || pop_ok, "result written over a waiting beat")
    `CRT_ASSERT_NEXT(a_disable_latches, clk, rst_n, result_we && res.engine_disable,
        fault_reg, "engine disable without latched fault")
    `CRT_ASSERT_NEXT(a_doorbell_closes, clk, rst_n, result_we && res.doorbell,
        remaining_reg == 3'd0, "doorbell left batch open")

endmodule
